// ----- design/text_to_u64_parser_assert.svh -----
// Assertion macros for the text_to_u64_parser top level.
`ifndef TEXT_TO_U64_PARSER_ASSERT_SVH
`define TEXT_TO_U64_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define TTU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("text_to_u64_parser: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define TTU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("text_to_u64_parser: next-cycle check failed");

`endif

// ----- design/ttu_pkg.sv -----
// Types, constants and character helpers for the text_to_u64_parser block.
package ttu_pkg;

  localparam int MAX_CHARS_DEF = 1023;
  localparam int VALUE_W       = 64;
  localparam int BASE_W        = 6;
  localparam int CH_W          = 8;
  localparam int END_W         = 10;

  // Conversion phases.
  typedef enum logic [2:0] {
    PH_FINISHED,
    PH_SPACE,
    PH_LEAD,
    PH_ZERO,
    PH_XPREFIX,
    PH_DIGITS
  } phase_t;

  // Digit status of the string in progress.
  typedef enum logic [1:0] {
    ST_NONE,
    ST_SEEN,
    ST_OVF
  } dstat_t;

  // Characters and bases.
  localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CH_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CH_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CH_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CH_W-1:0] CH_UA     = 8'h41;
  localparam logic [CH_W-1:0] CH_UZ     = 8'h5A;
  localparam logic [CH_W-1:0] CH_LA     = 8'h61;
  localparam logic [CH_W-1:0] CH_LZ     = 8'h7A;
  localparam logic [CH_W-1:0] CH_LX     = 8'h78;
  localparam logic [CH_W-1:0] CH_UX     = 8'h58;
  localparam logic [CH_W-1:0] UA_OFS    = 8'h37;  // 'A' - 10
  localparam logic [CH_W-1:0] LA_OFS    = 8'h57;  // 'a' - 10

  localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_W-1:0] BASE_ONE  = 6'd1;
  localparam logic [BASE_W-1:0] BASE_TWO  = 6'd2;
  localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
  localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;
  localparam logic [BASE_W-1:0] NOT_DIGIT = 6'd63;

  // Conversion state without the position counter.
  typedef struct packed {
    phase_t              phase;
    logic [VALUE_W-1:0]  acc;
    logic [BASE_W-1:0]   base;
    logic                neg;
    dstat_t              status;
  } conv_state_t;

  // One result from the step logic.
  typedef struct packed {
    logic                emit;
    logic [VALUE_W-1:0]  value;
    logic                ovf;
    logic                seen;
    logic [END_W-1:0]    end_offset;
  } conv_result_t;

  function automatic logic is_space(input logic [CH_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [BASE_W-1:0] digit_value(input logic [CH_W-1:0] c);
    logic [CH_W-1:0] t;
    t = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      t = c - CH_ZERO;
      return t[BASE_W-1:0];
    end
    if (c >= CH_UA && c <= CH_UZ) begin
      t = c - UA_OFS;
      return t[BASE_W-1:0];
    end
    if (c >= CH_LA && c <= CH_LZ) begin
      t = c - LA_OFS;
      return t[BASE_W-1:0];
    end
    return NOT_DIGIT;
  endfunction

  // Builds the result from the state at the terminating character.
  function automatic conv_result_t make_result(input conv_state_t s,
                                               input logic [END_W-1:0] e);
    conv_result_t r;
    r.emit = 1'b1;
    r.ovf  = (s.status == ST_OVF);
    r.seen = (s.status != ST_NONE);
    if (r.ovf) begin
      r.value = '1;
    end else if (s.neg) begin
      r.value = '0 - s.acc;
    end else begin
      r.value = s.acc;
    end
    r.end_offset = r.seen ? e : '0;
    return r;
  endfunction

endpackage

// ----- design/ttu_step.sv -----
// Combinational next-state and result logic for one character.
module ttu_step
  import ttu_pkg::*;
#(
  parameter int MAX_CHARS = MAX_CHARS_DEF
) (
  input  conv_state_t                      st,
  input  logic [$clog2(MAX_CHARS+1)-1:0]   pos,
  input  logic                             start_req,
  input  logic [CH_W-1:0]                  ch,
  input  logic [BASE_W-1:0]                base_request,
  output conv_state_t                      st_next,
  output logic [$clog2(MAX_CHARS+1)-1:0]   pos_next,
  output conv_result_t                     res
);

  localparam int POS_W = $clog2(MAX_CHARS+1);
  localparam int EXT_W = (POS_W > END_W) ? POS_W : END_W;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_CHARS);

  conv_state_t           work;
  logic                  active;
  logic                  lead;
  logic                  digit;
  logic [BASE_W-1:0]     d;
  logic [VALUE_W+BASE_W-1:0] prod;
  logic [EXT_W-1:0]      pos_ext;
  logic [EXT_W-1:0]      pos_prev_ext;

  assign d            = digit_value(ch);
  assign pos_ext      = EXT_W'(pos);
  assign pos_prev_ext = EXT_W'(pos - POS_W'(1));

  // Walk the phases for the current character in model order.
  always_comb begin
    work   = st;
    res    = '0;
    active = 1'b0;
    lead   = 1'b0;
    digit  = 1'b0;
    prod   = '0;

    if (start_req) begin
      work.acc    = '0;
      work.neg    = 1'b0;
      work.status = ST_NONE;
      work.base   = base_request;
      if (base_request == BASE_ONE || base_request > BASE_MAX) begin
        work.base  = BASE_AUTO;
        res        = make_result(work, '0);
        work.phase = PH_FINISHED;
      end else begin
        work.phase = PH_SPACE;
        active     = 1'b1;
      end
    end else if (st.phase != PH_FINISHED) begin
      active = 1'b1;
    end

    // Phase dispatch.
    if (active) begin
      unique case (work.phase)
        PH_SPACE: begin
          if (is_space(ch)) begin
            work.phase = PH_SPACE;
          end else if (ch == CH_MINUS || ch == CH_PLUS) begin
            work.neg   = (ch == CH_MINUS);
            work.phase = PH_LEAD;
          end else begin
            lead = 1'b1;
          end
        end
        PH_LEAD: begin
          lead = 1'b1;
        end
        PH_ZERO: begin
          if (ch == CH_LX || ch == CH_UX) begin
            work.phase = PH_XPREFIX;
          end else begin
            if (work.base == BASE_AUTO) work.base = BASE_OCT;
            digit = 1'b1;
          end
        end
        PH_XPREFIX: begin
          work.base = BASE_HEX;
          if (d < BASE_HEX) begin
            digit = 1'b1;
          end else begin
            res        = make_result(work, pos_prev_ext[END_W-1:0]);
            work.phase = PH_FINISHED;
          end
        end
        PH_DIGITS: begin
          digit = 1'b1;
        end
        default: begin
          work.phase = PH_FINISHED;
        end
      endcase
    end

    // First significant character: a zero may open a hex or octal prefix.
    if (lead) begin
      if (ch == CH_ZERO && (work.base == BASE_AUTO || work.base == BASE_HEX)) begin
        work.acc    = '0;
        work.status = ST_SEEN;
        work.phase  = PH_ZERO;
      end else begin
        if (work.base == BASE_AUTO) work.base = BASE_DEC;
        digit = 1'b1;
      end
    end

    // Accumulate one digit or terminate on a non-digit.
    if (digit) begin
      work.phase = PH_DIGITS;
      if (work.base < BASE_TWO || d >= work.base) begin
        res        = make_result(work, pos_ext[END_W-1:0]);
        work.phase = PH_FINISHED;
      end else begin
        prod = work.acc * (VALUE_W+BASE_W)'(work.base)
             + (VALUE_W+BASE_W)'(d);
        if (work.status == ST_OVF || prod[VALUE_W+BASE_W-1:VALUE_W] != '0) begin
          work.status = ST_OVF;
        end else begin
          work.acc    = prod[VALUE_W-1:0];
          work.status = ST_SEEN;
        end
      end
    end
  end

  // Position: cleared on start, advanced after a processed character.
  always_comb begin
    pos_next = start_req ? '0 : pos;
    if (active && pos_next < POS_MAX) pos_next = pos_next + POS_W'(1);
  end

  assign st_next = work;

endmodule

// ----- design/text_to_u64_parser.sv -----
// Top level of the streaming string to unsigned 64-bit converter.
//
// Converts a text number the way strtoull does: one character per transfer on
// the slave side, start_req (in s_tuser) marking the first character and its
// base (0 for automatic, 2 to 36). Leading whitespace, one sign and a 0x/0X
// prefix are handled; the first character that is not a digit in the active
// base ends the string and gives one transfer on the master side with the
// value (saturated to all ones on overflow, negated after '-'), the overflow
// and digits-seen flags and the end offset. An invalid base gives a zero
// result on the start character. The block takes one character per cycle unless
// a result finds the output full: each character passes an input register, then
// a single 64x6 multiply-add with its overflow check updates the state and, when
// the string ends, loads the output register. A character that gives no result
// keeps moving while a result waits.
module text_to_u64_parser
  import ttu_pkg::*;
#(
  parameter int MAX_CHARS = MAX_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] ch, [13:8] base_request, [15:14] zero
  input  logic        s_tuser,   // [0] start_req
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata    // [63:0] value, [64] overflow, [65] digits_seen,
                                 // [75:66] end_offset, [79:76] zero
);

  `include "text_to_u64_parser_assert.svh"

  localparam int POS_W = $clog2(MAX_CHARS+1);

  // Input register.
  logic                stage_valid;
  logic                stage_start;
  logic [CH_W-1:0]     stage_ch;
  logic [BASE_W-1:0]   stage_breq;

  // Conversion state.
  conv_state_t         st;
  conv_state_t         st_next;
  logic [POS_W-1:0]    pos;
  logic [POS_W-1:0]    pos_next;
  conv_result_t        res;

  // Output register.
  logic                out_valid;
  logic [VALUE_W-1:0]  out_value;
  logic                out_ovf;
  logic                out_seen;
  logic [END_W-1:0]    out_end;

  logic                advance;

  ttu_step #(
    .MAX_CHARS (MAX_CHARS)
  ) u_step (
    .st           (st),
    .pos          (pos),
    .start_req    (stage_start),
    .ch           (stage_ch),
    .base_request (stage_breq),
    .st_next      (st_next),
    .pos_next     (pos_next),
    .res          (res)
  );

  // The staged character moves on unless its result finds the output full.
  assign advance  = stage_valid && (!res.emit || !out_valid || m_tready);
  assign s_tready = !stage_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_tready) begin
      stage_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      stage_start <= s_tuser;
      stage_ch    <= s_tdata[CH_W-1:0];
      stage_breq  <= s_tdata[CH_W+BASE_W-1:CH_W];
    end
  end

  // Conversion state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase  <= PH_FINISHED;
      st.acc    <= '0;
      st.base   <= BASE_AUTO;
      st.neg    <= 1'b0;
      st.status <= ST_NONE;
      pos       <= '0;
    end else if (advance) begin
      st  <= st_next;
      pos <= pos_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      out_value <= res.value;
      out_ovf   <= res.ovf;
      out_seen  <= res.seen;
      out_end   <= res.end_offset;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_end, out_seen, out_ovf, out_value};

  // Checks on the conversion logic.
  `TTU_ASSERT_NOW(a_ovf_saturates, out_valid && out_ovf, out_value == '1 && out_seen)
  `TTU_ASSERT_NOW(a_no_digits_zero, out_valid && !out_seen,
                  out_end == '0 && out_value == '0 && !out_ovf)
  `TTU_ASSERT_NOW(a_pos_bound, 1'b1, pos <= POS_W'(MAX_CHARS))
  `TTU_ASSERT_NEXT(a_stage_holds, stage_valid && !advance,
                   stage_valid && $stable(stage_ch) && $stable(stage_start))
  `TTU_ASSERT_NEXT(a_ovf_sticky, advance && st.status == ST_OVF && !stage_start
                   && st_next.phase == PH_DIGITS, st.status == ST_OVF)

endmodule

// ----- test/ttu_result_checker.sv -----
// Result checker for text_to_u64_parser: predicts each conversion and compares the results.
module ttu_result_checker
  import ttu_pkg::*;
#(
  parameter int MAX_CHARS = MAX_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] ch, [13:8] base_request, [15:14] zero
  input  logic        s_tuser,   // [0] start_req
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [79:0] m_tdata,   // [63:0] value, [64] overflow, [65] digits_seen,
                                 // [75:66] end_offset, [79:76] zero
  output int          outstanding,
  output int          mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NO_WEIGHT = 99;

  // One converted number as it should leave the block.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               ovf;
    logic               seen;
    logic [END_W-1:0]   end_ofs;
  } conv_out_t;

  conv_out_t pending_conversions[$];

  // Predicted conversion state.
  phase_t             ph;
  logic [VALUE_W-1:0] acc;
  logic [BASE_W-1:0]  base;
  logic               neg;
  dstat_t             status;
  logic [END_W-1:0]   pos;
  int                 errs;

  function automatic int char_weight(input logic [CH_W-1:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_UA && c <= CH_UZ) return int'(c - UA_OFS);
    if (c >= CH_LA && c <= CH_LZ) return int'(c - LA_OFS);
    return NO_WEIGHT;
  endfunction

  function automatic logic is_blank(input logic [CH_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // The string ends here: queue the number it gave.
  task automatic conclude(input logic [END_W-1:0] end_at);
    conv_out_t r;
    r.ovf  = (status == ST_OVF);
    r.seen = (status != ST_NONE);
    if (r.ovf) begin
      r.value = {VALUE_W{1'b1}};
    end else if (neg) begin
      r.value = {VALUE_W{1'b0}} - acc;
    end else begin
      r.value = acc;
    end
    r.end_ofs = r.seen ? end_at : '0;
    pending_conversions.push_back(r);
    ph = PH_FINISHED;
  endtask

  // Adds one digit, or ends the string on a character outside the base.
  task automatic accumulate(input logic [CH_W-1:0] c);
    int                 d;
    logic [VALUE_W-1:0] cutoff;
    logic [VALUE_W-1:0] cutlim;
    d  = char_weight(c);
    ph = PH_DIGITS;
    if (base < BASE_TWO || d >= int'(base)) begin
      conclude(pos);
      return;
    end
    cutoff = {VALUE_W{1'b1}} / VALUE_W'(base);
    cutlim = {VALUE_W{1'b1}} % VALUE_W'(base);
    if (status == ST_OVF || acc > cutoff || (acc == cutoff && VALUE_W'(d) > cutlim)) begin
      status = ST_OVF;
    end else begin
      acc    = acc * VALUE_W'(base) + VALUE_W'(d);
      status = ST_SEEN;
    end
  endtask

  // First character after whitespace and sign; a zero may open a prefix.
  task automatic take_lead(input logic [CH_W-1:0] c);
    if (c == CH_ZERO && (base == BASE_AUTO || base == BASE_HEX)) begin
      acc    = '0;
      status = ST_SEEN;
      ph     = PH_ZERO;
    end else begin
      if (base == BASE_AUTO) base = BASE_DEC;
      accumulate(c);
    end
  endtask

  // Advances the predicted state by one accepted character.
  task automatic convert_char(input logic first, input logic [CH_W-1:0] c,
                              input logic [BASE_W-1:0] breq);
    if (first) begin
      acc    = '0;
      neg    = 1'b0;
      status = ST_NONE;
      pos    = '0;
      base   = breq;
      if (breq == BASE_ONE || breq > BASE_MAX) begin
        base = BASE_AUTO;
        conclude('0);
        return;
      end
      ph = PH_SPACE;
    end else if (ph == PH_FINISHED) begin
      return;
    end
    case (ph)
      PH_SPACE: begin
        if (!is_blank(c)) begin
          if (c == CH_MINUS || c == CH_PLUS) begin
            neg = (c == CH_MINUS);
            ph  = PH_LEAD;
          end else begin
            take_lead(c);
          end
        end
      end
      PH_LEAD: take_lead(c);
      PH_ZERO: begin
        if (c == CH_LX || c == CH_UX) begin
          ph = PH_XPREFIX;
        end else begin
          if (base == BASE_AUTO) base = BASE_OCT;
          accumulate(c);
        end
      end
      PH_XPREFIX: begin
        // Without a hex digit after the x only the zero counts.
        base = BASE_HEX;
        if (char_weight(c) < 16) begin
          accumulate(c);
        end else begin
          conclude(pos - END_W'(1));
        end
      end
      PH_DIGITS: accumulate(c);
      default: ;
    endcase
    if (pos < END_W'(MAX_CHARS)) pos++;
  endtask

  task automatic note_failure(input string msg);
    errs++;
    if (errs <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // Watch both channels at every clock edge.
  always @(posedge clk) begin
    conv_out_t want;
    conv_out_t got;
    if (rst) begin
      ph     = PH_FINISHED;
      acc    = '0;
      base   = BASE_AUTO;
      neg    = 1'b0;
      status = ST_NONE;
      pos    = '0;
      pending_conversions.delete();
    end else begin
      if (s_tvalid && s_tready) convert_char(s_tuser, s_tdata[7:0], s_tdata[13:8]);
      if (m_tvalid && m_tready) begin
        got.value   = m_tdata[63:0];
        got.ovf     = m_tdata[64];
        got.seen    = m_tdata[65];
        got.end_ofs = m_tdata[75:66];
        if (pending_conversions.size() == 0) begin
          note_failure($sformatf("unexpected result: value %h ovf %b seen %b end %0d",
                                 got.value, got.ovf, got.seen, got.end_ofs));
        end else begin
          want = pending_conversions.pop_front();
          if (got.value !== want.value || got.ovf !== want.ovf ||
              got.seen !== want.seen || got.end_ofs !== want.end_ofs) begin
            note_failure($sformatf({"result mismatch: expected value %h ovf %b seen %b ",
                                    "end %0d, got value %h ovf %b seen %b end %0d"},
                                   want.value, want.ovf, want.seen, want.end_ofs,
                                   got.value, got.ovf, got.seen, got.end_ofs));
          end
        end
      end
    end
    outstanding <= pending_conversions.size();
    mismatches  <= errs;
  end

endmodule

// ----- test/tb_text_to_u64_parser.sv -----
// Testbench top for text_to_u64_parser: clock, reset, character stimulus and the verdict.
module tb_text_to_u64_parser
  import ttu_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_CHARS = 1400;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [7:0] ch, [13:8] base_request, [15:14] zero
  logic        s_tuser;   // [0] start_req
  logic        m_tvalid;
  logic        m_tready;
  logic [79:0] m_tdata;   // [63:0] value, [64] overflow, [65] digits_seen,
                          // [75:66] end_offset, [79:76] zero
  int          outstanding;
  int          mismatches;
  logic        calm = 1'b0;   // both sides skip idling while set

  always #5ns clk = ~clk;

  text_to_u64_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  ttu_result_checker u_result_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  // Give up if the run hangs.
  initial begin
    #10_000_000ns;
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: a random stall before each transfer.
  initial begin
    int gap;
    forever begin
      gap = calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  function automatic logic [CH_W-1:0] digit_char(input int d);
    if (d < 10) return CH_ZERO + CH_W'(d);
    return ($urandom_range(0, 1) ? CH_LA : CH_UA) + CH_W'(d - 10);
  endfunction

  function automatic logic [CH_W-1:0] blank_char();
    return ($urandom_range(0, 5) == 0) ? CH_SPACE : CH_TAB + CH_W'($urandom_range(0, 4));
  endfunction

  // One character transfer after a random gap.
  task automatic send_char(input logic first, input logic [CH_W-1:0] c,
                           input logic [BASE_W-1:0] breq);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= first;
    s_tdata  <= {2'b00, breq, c};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_text(input logic [CH_W-1:0] text[$], input logic [BASE_W-1:0] breq);
    foreach (text[i]) send_char(i == 0, text[i], breq);
  endtask

  // Stops sending and holds until every predicted result has been seen.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // A number string with random content; now and then noise or a cut-off string.
  task automatic make_number(output logic [CH_W-1:0] text[$], output logic [BASE_W-1:0] breq,
                             output bit whole);
    int eff;
    int lim;
    int ndig;
    int pick;
    bit lead;
    bit allmax;
    whole = 1'b1;
    lead  = 1'b0;
    if ($urandom_range(0, 9) == 0) begin
      breq = BASE_W'($urandom_range(0, 63));
      repeat ($urandom_range(1, 8)) text.push_back(CH_W'($urandom_range(0, 255)));
      whole = 1'b0;
      return;
    end
    case ($urandom_range(0, 7))
      0, 1:    breq = BASE_AUTO;
      2:       breq = BASE_HEX;
      3:       breq = BASE_DEC;
      4:       breq = BASE_OCT;
      5:       breq = BASE_TWO;
      6:       breq = BASE_MAX;
      default: breq = BASE_W'($urandom_range(2, 36));
    endcase
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) text.push_back(blank_char());
    pick = $urandom_range(0, 5);
    if (pick < 2) text.push_back(CH_MINUS);
    else if (pick == 2) text.push_back(CH_PLUS);
    eff = int'(breq);
    // Automatic base: pick hex, octal or decimal by the way the number opens.
    if (breq == BASE_AUTO) begin
      case ($urandom_range(0, 2))
        0: begin
          eff = 16;
          text.push_back(CH_ZERO);
          text.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
        end
        1: begin
          eff = 8;
          text.push_back(CH_ZERO);
        end
        default: begin
          eff  = 10;
          lead = 1'b1;
        end
      endcase
    end else if (breq == BASE_HEX && $urandom_range(0, 2) == 0) begin
      text.push_back(CH_ZERO);
      text.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
    end
    // Long digit runs land around the 64-bit limit of the base.
    lim = (eff <= 2) ? 64 : (eff <= 3) ? 41 : (eff <= 4) ? 32 : (eff <= 8) ? 22 :
          (eff <= 10) ? 20 : (eff <= 16) ? 16 : 13;
    ndig   = ($urandom_range(0, 2) == 0) ? $urandom_range(lim - 1, lim + 2) : $urandom_range(0, 6);
    allmax = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < ndig; i++) begin
      if (allmax) text.push_back(digit_char(eff - 1));
      else if (i == 0 && lead) text.push_back(digit_char($urandom_range(1, 9)));
      else text.push_back(digit_char($urandom_range(0, eff - 1)));
    end
    case ($urandom_range(0, 4))
      0:       text.push_back(8'h00);
      1:       text.push_back(CH_SPACE);
      2:       text.push_back((eff < 36) ? digit_char(eff) : 8'h2E);
      3:       text.push_back(8'h80 | CH_W'($urandom_range(0, 127)));
      default: text.push_back(CH_MINUS);
    endcase
    // Cut the string short so the next start abandons it.
    if (text.size() > 1 && $urandom_range(0, 9) == 0) begin
      whole = 1'b0;
      repeat ($urandom_range(1, text.size() - 1)) void'(text.pop_back());
    end
  endtask

  // A string near or beyond the length at which the position counter saturates.
  task automatic make_long_string(output logic [CH_W-1:0] text[$],
                                  output logic [BASE_W-1:0] breq);
    bit zeros;
    breq  = BASE_DEC;
    zeros = bit'($urandom_range(0, 1));
    repeat ($urandom_range(1015, 1030)) text.push_back(zeros ? CH_ZERO : blank_char());
    text.push_back(8'h37);
    text.push_back(8'h00);
  endtask

  // Stimulus and verdict.
  initial begin
    logic [CH_W-1:0]   text[$];
    logic [BASE_W-1:0] breq;
    bit                whole;
    int                chars_sent;
    int                strings;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tuser  <= 1'b0;
    s_tdata  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: an idle character, invalid bases, sign and prefix, a restart.
    send_char(1'b0, 8'h71, BASE_AUTO);
    send_char(1'b1, 8'h35, BASE_ONE);
    send_char(1'b1, 8'h35, 6'd37);
    send_char(1'b1, 8'h35, 6'h3F);
    text = '{CH_SPACE, CH_TAB, CH_MINUS, CH_ZERO, CH_LX, 8'h31, 8'h46, 8'h00};
    send_text(text, BASE_AUTO);
    text = '{CH_ZERO, CH_UX, 8'h67};
    send_text(text, BASE_HEX);
    text = '{CH_PLUS, 8'h37};
    send_text(text, BASE_DEC);
    text = '{8'h39, 8'h00};
    send_text(text, BASE_DEC);
    send_char(1'b1, 8'hFF, BASE_MAX);
    wait_drained();

    // Random strings, mostly well formed, with one long string early on.
    chars_sent = 0;
    strings    = 0;
    while (chars_sent < RANDOM_CHARS) begin
      calm = ($urandom_range(0, 5) == 0);
      text.delete();
      if (strings == 20) begin
        make_long_string(text, breq);
        whole = 1'b1;
      end else begin
        make_number(text, breq, whole);
      end
      send_text(text, breq);
      chars_sent += text.size();
      // After a finished string, extra characters without a start are ignored.
      if (whole && $urandom_range(0, 7) == 0)
        repeat ($urandom_range(1, 3))
          send_char(1'b0, CH_W'($urandom_range(0, 255)), BASE_W'($urandom_range(0, 63)));
      strings++;
      if (strings % 40 == 0) wait_drained();
    end
    s_tvalid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- text_to_u64_parser.f -----
+incdir+design
design/ttu_pkg.sv
design/ttu_step.sv
design/text_to_u64_parser.sv
test/ttu_result_checker.sv
test/tb_text_to_u64_parser.sv
